// File: sv/array_operand_register_file_core_macros.svh
// Assertion macros for the array operand register file core.
// Used by the checker module; depends on nothing else.
`ifndef ARRAY_OPERAND_REGISTER_FILE_CORE_MACROS_SVH
`define ARRAY_OPERAND_REGISTER_FILE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define AORF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aorf: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define AORF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aorf: next-cycle check failed");

`endif

// File: sv/aorf_pkg.sv
// Shared constants and types for the array operand register file core.
// Used by the control stage, the row stage and the top level; no dependencies.
package aorf_pkg;

   localparam int RING_DEPTH_DEF = 16;
   localparam int ROW_BYTES_DEF  = 16;
   localparam int BEAT_BYTES     = 16;
   localparam int CTRL_W         = 3;

   localparam logic [2:0] KERNEL_BASE_MASK = 3'h7;

   typedef struct packed {
      logic              row_valid;
      logic              row_last;
      logic              offset;
      logic              hit;
      logic              sel;
      logic [CTRL_W-1:0] state;
   } meta_type;

endpackage

// File: sv/aorf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// A read and a write to one address in the same cycle return the old data.
module aorf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/aorf_ctrl.sv
// Front stage: loading controller, ring pointers, burst counter and entry writes.
// Depends on aorf_pkg; drives the entry RAMs and the row stage.
module aorf_ctrl #(
   parameter int RING_DEPTH = 16,
   parameter int ROW_BYTES  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_clear,
   input  logic                          req_write_valid,
   input  logic [63:0]                   req_write_data_low,
   input  logic [63:0]                   req_write_data_high,
   input  logic [15:0]                   req_byte_mask,
   input  logic                          req_shift_mode,
   input  logic                          req_stride_mode,
   input  logic [3:0]                    req_kernel_size,
   input  logic                          req_read_enable,
   output aorf_pkg::meta_type            meta,
   output logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output logic                          wr_en_p,
   output logic [$clog2(RING_DEPTH)-1:0] wr_addr_p,
   output logic [(ROW_BYTES+2)*8-1:0]    wr_data_p,
   output logic                          wr_en_s,
   output logic [$clog2(RING_DEPTH)-1:0] wr_addr_s,
   output logic [(ROW_BYTES+2)*8-1:0]    wr_data_s
);

   import aorf_pkg::*;

   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int HALF        = RING_DEPTH / 2;
   localparam int ENTRY_BYTES = ROW_BYTES + 2;

   localparam logic [CTRL_W-1:0] ST_IDLE     = 3'd0;
   localparam logic [CTRL_W-1:0] ST_LOADING  = 3'd1;
   localparam logic [CTRL_W-1:0] ST_PADDING  = 3'd2;
   localparam logic [CTRL_W-1:0] ST_SHIFTING = 3'd3;
   localparam logic [CTRL_W-1:0] ST_STRIDING = 3'd4;
   localparam logic [CTRL_W-1:0] ST_STRSHIFT = 3'd5;
   localparam logic [CTRL_W-1:0] ST_STORING  = 3'd6;

   logic [CTRL_W-1:0]       state_ff, state_in, state_nxt;
   logic [PTR_W-1:0]        wp_ff, wp_in, wp_next;
   logic [CNT_W-1:0]        fill_ff, fill_in, fill_div;
   logic [PTR_W-1:0]        lrp_ff, lrp_in, lrp_next;
   logic [PTR_W-1:0]        hrp_ff, hrp_in, hrp_next;
   logic [7:0]              burst_ff, burst_in;
   logic                    high_ff, high_in;
   logic                    armed_ff, armed_in;
   logic [BEAT_BYTES*8-1:0] prev_ff, prev_in;
   logic [RING_DEPTH-1:0]   vld_ff, vld_in;
   logic [RING_DEPTH-1:0]   ins_ff, ins_in;

   logic [127:0]                        data_all;
   logic [BEAT_BYTES-1:0][7:0]          beat;
   logic [BEAT_BYTES-1:0][7:0]          prev;
   logic [ENTRY_BYTES-1:0][7:0]         ent_p, ent_s;
   logic [2:0]                          base;
   logic [1:0]                          ext_p1;
   logic [4:0]                          cycles;
   logic                                last, offset, use_high;
   logic [PTR_W-1:0]                    idx;
   logic [CNT_W-1:0]                    lrp_inc;
   logic [PTR_W:0]                      h_sum;
   logic [PTR_W-1:0]                    h_addr;

   assign data_all = {req_write_data_high, req_write_data_low};
   assign prev     = prev_ff;

   always_comb begin
      for (int i = 0; i < BEAT_BYTES; i++) begin
         beat[i] = req_byte_mask[i] ? data_all[i*8 +: 8] : 8'h00;
      end
   end

   for (genvar g = 0; g < ROW_BYTES; g++) begin : g_entry
      assign ent_p[g] = beat[g];
      if (2 * g + 1 < BEAT_BYTES) begin : g_odd
         assign ent_s[g] = beat[2*g+1];
      end else begin : g_prev
         assign ent_s[g] = prev[2*g+1-BEAT_BYTES];
      end
   end
   assign ent_p[ROW_BYTES]   = beat[0];
   assign ent_p[ROW_BYTES+1] = beat[1];
   assign ent_s[ROW_BYTES]   = beat[2];
   assign ent_s[ROW_BYTES+1] = beat[3];

   always_comb begin
      unique case (state_ff)
         ST_IDLE:     state_nxt = (req_write_valid && req_kernel_size != 4'd0) ?
                                  ST_LOADING : ST_IDLE;
         ST_LOADING: begin
            if (!req_write_valid)      state_nxt = ST_LOADING;
            else if (req_shift_mode)   state_nxt = ST_SHIFTING;
            else if (req_stride_mode)  state_nxt = ST_STRIDING;
            else                       state_nxt = ST_PADDING;
         end
         ST_PADDING:  state_nxt = req_write_valid ? ST_LOADING : ST_STORING;
         ST_SHIFTING: state_nxt = (req_stride_mode && req_write_valid) ?
                                  ST_STRIDING : ST_PADDING;
         ST_STRIDING: state_nxt = (req_shift_mode && req_write_valid) ?
                                  ST_STRSHIFT : ST_PADDING;
         ST_STRSHIFT: state_nxt = req_write_valid ? ST_PADDING : ST_STRSHIFT;
         ST_STORING:  state_nxt = req_write_valid ? ST_LOADING : ST_STORING;
         default:     state_nxt = (req_write_valid && req_kernel_size != 4'd0) ?
                                  ST_LOADING : ST_IDLE;
      endcase
   end

   always_comb begin
      base     = req_kernel_size[2:0] & KERNEL_BASE_MASK;
      if (base == 3'd0) begin
         base = 3'd1;
      end
      ext_p1   = 2'd1 + {1'b0, req_kernel_size >= 4'd2} + {1'b0, req_stride_mode};
      cycles   = 5'(base) * {3'b000, ext_p1};
      last     = burst_ff == {3'b000, cycles - 5'd1};
      offset   = (req_kernel_size <= 4'd3) && (burst_ff >= {5'b00000, base});
      use_high = req_shift_mode && high_ff;
      idx      = use_high ? hrp_ff : lrp_ff;

      fill_div = (fill_ff == '0) ? CNT_W'(1) : fill_ff;
      lrp_inc  = CNT_W'(lrp_ff) + CNT_W'(1);
      lrp_next = (lrp_inc >= fill_div) ? '0 : PTR_W'(lrp_inc);
      hrp_next = (hrp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : hrp_ff + PTR_W'(1);
      wp_next  = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
      h_sum    = {1'b0, wp_ff} + (PTR_W+1)'(HALF);
      h_addr   = (h_sum >= (PTR_W+1)'(RING_DEPTH)) ?
                 PTR_W'(h_sum - (PTR_W+1)'(RING_DEPTH)) : PTR_W'(h_sum);
   end

   always_comb begin
      state_in = req_clear ? ST_IDLE : state_nxt;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      lrp_in   = lrp_ff;
      hrp_in   = hrp_ff;
      burst_in = burst_ff;
      high_in  = high_ff;
      armed_in = armed_ff;
      prev_in  = prev_ff;
      vld_in   = vld_ff;
      ins_in   = ins_ff;
      if (req_clear) begin
         wp_in    = '0;
         fill_in  = '0;
         lrp_in   = '0;
         hrp_in   = PTR_W'(HALF);
         burst_in = '0;
         high_in  = 1'b0;
         armed_in = 1'b0;
      end else begin
         armed_in = armed_ff | req_read_enable;
         if (armed_ff) begin
            if (last) begin
               burst_in = '0;
               armed_in = req_read_enable;
               if (req_shift_mode) begin
                  high_in = ~high_ff;
               end
            end else begin
               burst_in = burst_ff + 8'd1;
               if (use_high) begin
                  hrp_in = hrp_next;
               end else begin
                  lrp_in = lrp_next;
               end
            end
         end
         if (req_write_valid) begin
            prev_in        = beat;
            wp_in          = wp_next;
            fill_in        = (fill_ff == CNT_W'(RING_DEPTH)) ? fill_ff : fill_ff + CNT_W'(1);
            vld_in[wp_ff]  = 1'b1;
            ins_in[wp_ff]  = 1'b0;
            if (req_shift_mode) begin
               vld_in[h_addr] = 1'b1;
               ins_in[h_addr] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         fill_ff  <= '0;
         lrp_ff   <= '0;
         hrp_ff   <= PTR_W'(HALF);
         burst_ff <= '0;
         high_ff  <= 1'b0;
         armed_ff <= 1'b0;
         prev_ff  <= '0;
         vld_ff   <= '0;
         ins_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         lrp_ff   <= lrp_in;
         hrp_ff   <= hrp_in;
         burst_ff <= burst_in;
         high_ff  <= high_in;
         armed_ff <= armed_in;
         prev_ff  <= prev_in;
         vld_ff   <= vld_in;
         ins_ff   <= ins_in;
      end
   end

   always_comb begin
      meta.row_valid = ~req_clear & armed_ff;
      meta.row_last  = ~req_clear & armed_ff & last;
      meta.offset    = ~req_clear & armed_ff & offset;
      meta.hit       = vld_ff[idx];
      meta.sel       = ins_ff[idx];
      meta.state     = state_in;
   end

   assign rd_addr   = idx;
   assign wr_en_p   = accept & ~req_clear & req_write_valid;
   assign wr_addr_p = wp_ff;
   assign wr_data_p = ent_p;
   assign wr_en_s   = accept & ~req_clear & req_write_valid & req_shift_mode;
   assign wr_addr_s = h_addr;
   assign wr_data_s = ent_s;

endmodule

// File: sv/aorf_row.sv
// Back stage: picks the entry read from the RAMs, applies the offset and
// holds the result beat in the output register. Depends on aorf_pkg.
module aorf_row #(
   parameter int ROW_BYTES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  aorf_pkg::meta_type         meta,
   input  logic [(ROW_BYTES+2)*8-1:0] dout_p,
   input  logic [(ROW_BYTES+2)*8-1:0] dout_s,
   input  logic                       rsp_stall,
   output logic                       in_stall,
   output logic                       rsp_valid,
   output logic                       rsp_row_valid,
   output logic                       rsp_row_last,
   output logic [63:0]                rsp_row_data_low,
   output logic [63:0]                rsp_row_data_high,
   output logic [2:0]                 rsp_controller_state
);

   import aorf_pkg::*;

   localparam int ENTRY_BYTES = ROW_BYTES + 2;

   logic                        s1_valid_ff, s1_valid_in;
   meta_type                    s1_meta_ff;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_row_valid_ff, out_row_last_ff;
   logic [127:0]                out_data_ff;
   logic [CTRL_W-1:0]           out_state_ff;
   logic                        s1_go;
   logic                        show;
   logic [ENTRY_BYTES-1:0][7:0] ent;
   logic [15:0][7:0]            row;

   assign ent  = s1_meta_ff.sel ? dout_s : dout_p;
   assign show = s1_meta_ff.row_valid & s1_meta_ff.hit;

   for (genvar g = 0; g < 16; g++) begin : g_row
      if (g < ROW_BYTES) begin : g_used
         assign row[g] = !show ? 8'h00 : (s1_meta_ff.offset ? ent[g+2] : ent[g]);
      end else begin : g_pad
         assign row[g] = 8'h00;
      end
   end

   assign s1_go        = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign in_stall     = s1_valid_ff & ~s1_go;
   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_go);
   assign out_valid_in = s1_go | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_go) begin
         out_row_valid_ff <= s1_meta_ff.row_valid;
         out_row_last_ff  <= s1_meta_ff.row_last;
         out_data_ff      <= row;
         out_state_ff     <= s1_meta_ff.state;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_row_valid        = out_row_valid_ff;
   assign rsp_row_last         = out_row_last_ff;
   assign rsp_row_data_low     = out_data_ff[63:0];
   assign rsp_row_data_high    = out_data_ff[127:64];
   assign rsp_controller_state = out_state_ff;

endmodule

// File: sv/array_operand_register_file_core.sv
// Operand register file for a systolic array: control stage, two entry RAMs
// and the row stage. Depends on aorf_pkg, aorf_ram, aorf_ctrl and aorf_row.
//
// Usage. Every request beat carries one clock's worth of array inputs: an
// optional write beat with its byte mask, the shift, stride and kernel flags,
// the read enable and the clear flag. Every accepted request beat yields
// exactly one response beat, in order, carrying the row read out (or zeros
// with row_valid low) and the loading controller state after that beat.
// A request beat passes the RAM read stage, then the output register.
// Throughput: one request beat per cycle while req_stall is low, set by
// the single write and single read port of each entry RAM; plain entries live
// in one RAM and shift-mode ones in the other, so a beat writes both at once.
// A read in the same cycle as a write sees the entries from before the write.
// Reset clears the controller, pointers and per-entry valid bits at once;
// an entry never written since reset reads as zero, with no clearing pass.
// When rsp_stall is high the output register holds its beat, one further
// beat waits in the RAM read stage, and req_stall then rises until the
// output drains.
module array_operand_register_file_core #(
   parameter int RING_DEPTH = aorf_pkg::RING_DEPTH_DEF,
   parameter int ROW_BYTES  = aorf_pkg::ROW_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_clear,
   input  logic        req_write_valid,
   input  logic [63:0] req_write_data_low,
   input  logic [63:0] req_write_data_high,
   input  logic [15:0] req_byte_mask,
   input  logic        req_shift_mode,
   input  logic        req_stride_mode,
   input  logic [3:0]  req_kernel_size,
   input  logic        req_read_enable,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_row_valid,
   output logic        rsp_row_last,
   output logic [63:0] rsp_row_data_low,
   output logic [63:0] rsp_row_data_high,
   output logic [2:0]  rsp_controller_state
);

   import aorf_pkg::*;

   localparam int PTR_W   = $clog2(RING_DEPTH);
   localparam int ENTRY_W = (ROW_BYTES + 2) * 8;

   logic               accept;
   meta_type           meta;
   logic [PTR_W-1:0]   rd_addr;
   logic               wr_en_p, wr_en_s;
   logic [PTR_W-1:0]   wr_addr_p, wr_addr_s;
   logic [ENTRY_W-1:0] wr_data_p, wr_data_s;
   logic [ENTRY_W-1:0] dout_p, dout_s;

   assign accept = req_valid & ~req_stall;

   aorf_ctrl #(
      .RING_DEPTH(RING_DEPTH),
      .ROW_BYTES (ROW_BYTES)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_clear          (req_clear),
      .req_write_valid    (req_write_valid),
      .req_write_data_low (req_write_data_low),
      .req_write_data_high(req_write_data_high),
      .req_byte_mask      (req_byte_mask),
      .req_shift_mode     (req_shift_mode),
      .req_stride_mode    (req_stride_mode),
      .req_kernel_size    (req_kernel_size),
      .req_read_enable    (req_read_enable),
      .meta               (meta),
      .rd_addr            (rd_addr),
      .wr_en_p            (wr_en_p),
      .wr_addr_p          (wr_addr_p),
      .wr_data_p          (wr_data_p),
      .wr_en_s            (wr_en_s),
      .wr_addr_s          (wr_addr_s),
      .wr_data_s          (wr_data_s)
   );

   aorf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(RING_DEPTH)
   ) u_ram_plain (
      .clock  (clock),
      .wr_en  (wr_en_p),
      .wr_addr(wr_addr_p),
      .wr_data(wr_data_p),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(dout_p)
   );

   aorf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(RING_DEPTH)
   ) u_ram_shift (
      .clock  (clock),
      .wr_en  (wr_en_s),
      .wr_addr(wr_addr_s),
      .wr_data(wr_data_s),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(dout_s)
   );

   aorf_row #(
      .ROW_BYTES(ROW_BYTES)
   ) u_row (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .meta                (meta),
      .dout_p              (dout_p),
      .dout_s              (dout_s),
      .rsp_stall           (rsp_stall),
      .in_stall            (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_row_valid       (rsp_row_valid),
      .rsp_row_last        (rsp_row_last),
      .rsp_row_data_low    (rsp_row_data_low),
      .rsp_row_data_high   (rsp_row_data_high),
      .rsp_controller_state(rsp_controller_state)
   );

endmodule

// File: sv/aorf_checker.sv
// Port-level checks for the array operand register file core, bound to the top.
// Depends on array_operand_register_file_core_macros.svh.
`include "array_operand_register_file_core_macros.svh"

module aorf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_row_valid,
   input logic        rsp_row_last,
   input logic [63:0] rsp_row_data_low,
   input logic [63:0] rsp_row_data_high,
   input logic [2:0]  rsp_controller_state
);

   `AORF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_row_data_low) && $stable(rsp_row_data_high) && $stable(rsp_controller_state))
   `AORF_ASSERT_IMP(a_empty_row_zero, clock, reset, rsp_valid && !rsp_row_valid, !rsp_row_last && rsp_row_data_low == 64'd0 && rsp_row_data_high == 64'd0)
   `AORF_ASSERT_IMP(a_last_is_row, clock, reset, rsp_valid && rsp_row_last, rsp_row_valid)
   `AORF_ASSERT_IMP(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `AORF_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind array_operand_register_file_core aorf_checker u_aorf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_row_valid       (rsp_row_valid),
   .rsp_row_last        (rsp_row_last),
   .rsp_row_data_low    (rsp_row_data_low),
   .rsp_row_data_high   (rsp_row_data_high),
   .rsp_controller_state(rsp_controller_state)
);

// File: tb/aorf_row_checker.sv
`timescale 1ns / 100ps
// Checker for the array operand register file core: watches both channels,
// predicts each response beat from the request beats and compares them.
// Depends on aorf_pkg for the ring and row sizes.
module aorf_row_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_clear,
   input  logic        req_write_valid,
   input  logic [63:0] req_write_data_low,
   input  logic [63:0] req_write_data_high,
   input  logic [15:0] req_byte_mask,
   input  logic        req_shift_mode,
   input  logic        req_stride_mode,
   input  logic [3:0]  req_kernel_size,
   input  logic        req_read_enable,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_row_valid,
   input  logic        rsp_row_last,
   input  logic [63:0] rsp_row_data_low,
   input  logic [63:0] rsp_row_data_high,
   input  logic [2:0]  rsp_controller_state,
   output int          fail_count,
   output int          rows_pending
);
   import aorf_pkg::*;

   localparam int DEPTH     = RING_DEPTH_DEF;
   localparam int ROW       = ROW_BYTES_DEF;
   localparam int ENTRY_LEN = ROW + 2;

   typedef enum logic [2:0] {
      CTRL_IDLE, CTRL_LOADING, CTRL_PADDING, CTRL_SHIFTING,
      CTRL_STRIDING, CTRL_STRIDE_SHIFT, CTRL_STORING
   } ctrl_type;

   typedef struct {
      logic        valid;
      logic        last;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [2:0]  state;
   } row_beat_type;

   logic [7:0]   entry_mem [DEPTH][ENTRY_LEN];
   logic [7:0]   last_beat [BEAT_BYTES];
   int unsigned  wr_ptr, fill_cnt, lo_ptr, hi_ptr;
   logic [7:0]   burst_cnt;
   bit           high_half, armed;
   ctrl_type     ctrl;
   row_beat_type expected_rows [$];
   int           mismatches = 0;

   function automatic ctrl_type step_loader(ctrl_type s, bit wv, bit sh, bit st,
                                            logic [3:0] k);
      case (s)
         CTRL_LOADING: begin
            if (!wv) return CTRL_LOADING;
            if (sh) return CTRL_SHIFTING;
            if (st) return CTRL_STRIDING;
            return CTRL_PADDING;
         end
         CTRL_PADDING:      return wv ? CTRL_LOADING : CTRL_STORING;
         CTRL_SHIFTING:     return (st && wv) ? CTRL_STRIDING : CTRL_PADDING;
         CTRL_STRIDING:     return (sh && wv) ? CTRL_STRIDE_SHIFT : CTRL_PADDING;
         CTRL_STRIDE_SHIFT: return wv ? CTRL_PADDING : CTRL_STRIDE_SHIFT;
         CTRL_STORING:      return wv ? CTRL_LOADING : CTRL_STORING;
         default:           return (wv && k >= 1) ? CTRL_LOADING : CTRL_IDLE;
      endcase
   endfunction

   task automatic reset_pointers();
      ctrl      = CTRL_IDLE;
      wr_ptr    = 0;
      fill_cnt  = 0;
      lo_ptr    = 0;
      hi_ptr    = DEPTH / 2;
      burst_cnt = '0;
      high_half = 1'b0;
      armed     = 1'b0;
   endtask

   task automatic predict_row_beat(bit clr, bit wv, logic [63:0] dlo,
                                   logic [63:0] dhi, logic [15:0] mask,
                                   bit sh, bit st, logic [3:0] k, bit re);
      row_beat_type row;
      logic [7:0]   beat [BEAT_BYTES];
      int unsigned  base, span, idx, off, b, w, h, fill;
      bit           use_high, was_armed;
      row.valid = 1'b0;
      row.last  = 1'b0;
      row.lo    = '0;
      row.hi    = '0;
      ctrl = step_loader(ctrl, wv, sh, st, k);
      if (clr) begin
         reset_pointers();
      end else begin
         was_armed = armed;
         if (re) armed = 1'b1;
         if (was_armed) begin
            base = {29'd0, k[2:0]};
            if (base == 0) base = 1;
            span = base * (1 + (k >= 2 ? 1 : 0) + (st ? 1 : 0));
            use_high = sh && high_half;
            idx = use_high ? hi_ptr : lo_ptr;
            off = (k <= 3 && {24'd0, burst_cnt} >= base) ? 2 : 0;
            for (int i = 0; i < ROW; i++) begin
               b = i + off;
               if (b > ENTRY_LEN - 1) b = ENTRY_LEN - 1;
               if (i < 8) row.lo[i*8 +: 8] = entry_mem[idx][b];
               else row.hi[(i-8)*8 +: 8] = entry_mem[idx][b];
            end
            row.valid = 1'b1;
            row.last  = ({24'd0, burst_cnt} == span - 1);
            if (row.last) begin
               burst_cnt = '0;
               armed     = re;
               if (sh) high_half = !high_half;
            end else begin
               burst_cnt = burst_cnt + 8'd1;
               if (use_high) begin
                  hi_ptr = (hi_ptr + 1) % DEPTH;
               end else begin
                  fill   = (fill_cnt == 0) ? 1 : fill_cnt;
                  lo_ptr = (lo_ptr + 1) % fill;
               end
            end
         end
         if (wv) begin
            for (int i = 0; i < BEAT_BYTES; i++) begin
               if (!mask[i]) beat[i] = 8'h00;
               else if (i < 8) beat[i] = dlo[i*8 +: 8];
               else beat[i] = dhi[(i-8)*8 +: 8];
            end
            w = wr_ptr;
            for (int i = 0; i < ROW; i++) entry_mem[w][i] = beat[i];
            entry_mem[w][ROW]     = beat[0];
            entry_mem[w][ROW + 1] = beat[1];
            if (sh) begin
               h = (w + DEPTH / 2) % DEPTH;
               for (int i = 0; i < ROW; i++) begin
                  b = i * 2 + 1;
                  entry_mem[h][i] = (b < BEAT_BYTES) ? beat[b]
                                  : last_beat[(b - BEAT_BYTES) % BEAT_BYTES];
               end
               entry_mem[h][ROW]     = beat[2];
               entry_mem[h][ROW + 1] = beat[3];
            end
            last_beat = beat;
            wr_ptr = (w + 1) % DEPTH;
            if (fill_cnt < DEPTH) fill_cnt++;
         end
      end
      row.state = ctrl;
      expected_rows.push_back(row);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic compare_row();
      row_beat_type want;
      if (expected_rows.size() == 0) begin
         mismatches++;
         $display("%0t: response beat with none expected, expected nothing, actual %h_%h",
                  $time, rsp_row_data_high, rsp_row_data_low);
      end else begin
         want = expected_rows.pop_front();
         check_field("row_valid", {63'd0, want.valid}, {63'd0, rsp_row_valid});
         check_field("row_last", {63'd0, want.last}, {63'd0, rsp_row_last});
         check_field("row_data_low", want.lo, rsp_row_data_low);
         check_field("row_data_high", want.hi, rsp_row_data_high);
         check_field("controller_state", {61'd0, want.state}, {61'd0, rsp_controller_state});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < DEPTH; e++)
            for (int i = 0; i < ENTRY_LEN; i++) entry_mem[e][i] = 8'h00;
         for (int i = 0; i < BEAT_BYTES; i++) last_beat[i] = 8'h00;
         reset_pointers();
         expected_rows.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_row_beat(req_clear, req_write_valid, req_write_data_low,
                             req_write_data_high, req_byte_mask, req_shift_mode,
                             req_stride_mode, req_kernel_size, req_read_enable);
         if (rsp_valid && !rsp_stall) compare_row();
      end
      rows_pending <= expected_rows.size();
      fail_count   <= mismatches;
   end

endmodule

// File: tb/array_operand_register_file_core_tb.sv
`timescale 1ns / 100ps
// Top of the testbench for the array operand register file core: clock,
// reset, request and response stimulus, watchdog and verdict.
// Depends on array_operand_register_file_core and aorf_row_checker.
module array_operand_register_file_core_tb;

   localparam int RANDOM_BEATS = 1750;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_OFF     = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_clear = 1'b0;
   logic        req_write_valid = 1'b0;
   logic [63:0] req_write_data_low = '0;
   logic [63:0] req_write_data_high = '0;
   logic [15:0] req_byte_mask = '0;
   logic        req_shift_mode = 1'b0;
   logic        req_stride_mode = 1'b0;
   logic [3:0]  req_kernel_size = '0;
   logic        req_read_enable = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_row_valid;
   logic        rsp_row_last;
   logic [63:0] rsp_row_data_low;
   logic [63:0] rsp_row_data_high;
   logic [2:0]  rsp_controller_state;

   int fail_count;
   int rows_pending;
   int idle_cycles = 0;
   int burst_left  = 0;
   bit random_phase = 1'b0;

   always #5 clock = ~clock;

   array_operand_register_file_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_clear           (req_clear),
      .req_write_valid     (req_write_valid),
      .req_write_data_low  (req_write_data_low),
      .req_write_data_high (req_write_data_high),
      .req_byte_mask       (req_byte_mask),
      .req_shift_mode      (req_shift_mode),
      .req_stride_mode     (req_stride_mode),
      .req_kernel_size     (req_kernel_size),
      .req_read_enable     (req_read_enable),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_valid       (rsp_row_valid),
      .rsp_row_last        (rsp_row_last),
      .rsp_row_data_low    (rsp_row_data_low),
      .rsp_row_data_high   (rsp_row_data_high),
      .rsp_controller_state(rsp_controller_state)
   );

   aorf_row_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_clear           (req_clear),
      .req_write_valid     (req_write_valid),
      .req_write_data_low  (req_write_data_low),
      .req_write_data_high (req_write_data_high),
      .req_byte_mask       (req_byte_mask),
      .req_shift_mode      (req_shift_mode),
      .req_stride_mode     (req_stride_mode),
      .req_kernel_size     (req_kernel_size),
      .req_read_enable     (req_read_enable),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_valid       (rsp_row_valid),
      .rsp_row_last        (rsp_row_last),
      .rsp_row_data_low    (rsp_row_data_low),
      .rsp_row_data_high   (rsp_row_data_high),
      .rsp_controller_state(rsp_controller_state),
      .fail_count          (fail_count),
      .rows_pending        (rows_pending)
   );

   // Offers one request beat and returns at the edge that accepts it.
   task automatic send_beat(bit clr, bit wv, logic [63:0] dlo, logic [63:0] dhi,
                            logic [15:0] mask, bit sh, bit st, logic [3:0] k, bit re);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_clear           <= clr;
      req_write_valid     <= wv;
      req_write_data_low  <= dlo;
      req_write_data_high <= dhi;
      req_byte_mask       <= mask;
      req_shift_mode      <= sh;
      req_stride_mode     <= st;
      req_kernel_size     <= k;
      req_read_enable     <= re;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] random_mask();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 16'hFFFF;
      if (pick < 9) return 16'($urandom_range(0, 16'hFFFF));
      return 16'h0000;
   endfunction

   initial begin : stimulus
      logic [3:0]  ep_k;
      bit          ep_sh, ep_st, ep_re, wv, re;
      int          ep_left, ep_write_pct, pick;
      ep_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_beat(0, 0, '0, '0, 16'h0000, 0, 0, 4'd0, 1);
      send_beat(0, 1, '1, '1, 16'hFFFF, 0, 0, 4'd1, 1);
      send_beat(0, 1, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 16'hFFFF, 1, 0, 4'd1, 1);
      send_beat(0, 1, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 16'h0000, 1, 1, 4'd15, 1);
      send_beat(0, 1, '1, '0, 16'hA5C3, 1, 0, 4'd8, 1);
      send_beat(0, 0, '1, '1, 16'hFFFF, 0, 0, 4'd3, 1);
      send_beat(0, 1, 64'h8877665544332211, 64'h00FFEEDDCCBBAA99, 16'hFFFF, 0, 1, 4'd3, 1);
      send_beat(0, 0, '0, '0, 16'hFFFF, 0, 0, 4'd3, 1);
      send_beat(0, 0, '0, '0, 16'hFFFF, 0, 0, 4'd3, 1);
      send_beat(0, 1, '0, '1, 16'h5A5A, 0, 1, 4'd2, 1);
      send_beat(0, 1, '1, '0, 16'hFFFF, 0, 1, 4'd2, 1);
      send_beat(0, 0, '0, '0, 16'h0000, 0, 0, 4'd2, 1);
      send_beat(0, 1, random_word(), random_word(), 16'hFFFF, 0, 1, 4'd7, 1);
      send_beat(0, 1, random_word(), random_word(), 16'hFFFF, 0, 0, 4'd7, 1);
      for (int i = 0; i < 5; i++)
         send_beat(0, 0, '0, '0, 16'h0000, 1, 0, 4'd3, 1);
      send_beat(1, 1, '1, '1, 16'hFFFF, 1, 1, 4'd15, 1);
      send_beat(0, 1, '1, '1, 16'hFFFF, 0, 0, 4'd0, 1);
      send_beat(0, 1, random_word(), random_word(), 16'hFFFF, 1, 0, 4'd4, 0);
      send_beat(0, 0, '0, '0, 16'h0000, 0, 0, 4'd4, 0);

      // Random phase opens with a gapless burst while the receiver holds off, so the core fills up.
      random_phase <= 1'b1;
      burst_left = 80;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (ep_left == 0) begin
            ep_k         = 4'($urandom_range(0, 15));
            ep_sh        = 1'($urandom_range(0, 1));
            ep_st        = 1'($urandom_range(0, 1));
            ep_re        = ($urandom_range(0, 4) != 0);
            ep_write_pct = $urandom_range(40, 100);
            ep_left      = $urandom_range(4, 40);
         end
         ep_left--;
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            send_beat(1, 1'($urandom_range(0, 1)), random_word(), random_word(),
                      random_mask(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
         end else if (pick < 12) begin
            send_beat(0, 1'($urandom_range(0, 1)), random_word(), random_word(),
                      16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
         end else begin
            wv = ($urandom_range(1, 100) <= ep_write_pct);
            re = ($urandom_range(0, 9) == 0) ? !ep_re : ep_re;
            send_beat(0, wv, random_word(), random_word(), random_mask(),
                      ep_sh, ep_st, ep_k, re);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && rows_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : receiver
      int mode, span;
      while (!random_phase) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
         @(posedge clock);
      end
      rsp_stall <= 1'b1;
      repeat (HOLD_OFF) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(5, 60);
         for (int c = 0; c < span; c++) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= (c % 4 == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: array_operand_register_file_core.f
+incdir+sv
sv/aorf_pkg.sv
sv/aorf_ram.sv
sv/aorf_ctrl.sv
sv/aorf_row.sv
sv/array_operand_register_file_core.sv
sv/aorf_checker.sv
tb/aorf_row_checker.sv
tb/array_operand_register_file_core_tb.sv
